### design/bdr_pkg.sv
// Shared types and constants for the bidi level-run reorder block.
// Used by the front end, the line descriptor queue, the back end and the top level.
package bdr_pkg;

   localparam int IDX_W = 16;
   localparam int LVL_W = 7;
   localparam int ODD_W = 8;

   // Lowest odd level value that means no odd level was seen on the line
   localparam logic [ODD_W-1:0] NO_ODD_LEVEL = 8'd255;

   // One stored word: index and embedding level
   typedef struct packed {
      logic [IDX_W-1:0] word_index;
      logic [LVL_W-1:0] level;
   } entry_type;

   // Per-line summary handed from the front end to the back end
   typedef struct packed {
      logic [LVL_W-1:0] highest;
      logic [ODD_W-1:0] lowest_odd;
      logic             overflow;
   } line_info_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN_ISSUE,
      BK_SCAN,
      BK_REV,
      BK_COPY,
      BK_EMIT_ISSUE,
      BK_EMIT
   } back_state_type;

endpackage

### design/bdr_front.sv
// Front end: accepts words, writes them into a two-bank line store, tracks level summary.
// Depends on bdr_pkg.
module bdr_front import bdr_pkg::*; #(
   parameter int MAX_WORDS = 64,
   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
   localparam int CW = $clog2(MAX_WORDS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [IDX_W-1:0]    req_word_index,
   input  logic [LVL_W-1:0]    req_embed_level,
   input  logic                req_last_word,
   output logic                busy,
   input  logic                release_line,
   output logic                push,
   output logic                push_bank,
   output logic [CW-1:0]       push_count,
   output line_info_type       push_info,
   input  logic                rd_bank,
   input  logic [AW-1:0]       rd_addr,
   output entry_type           rd_data
);

   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_WORDS);

   entry_type          store_mem [2][MAX_WORDS];
   entry_type          rd_data_ff;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [LVL_W-1:0]   hi_ff, hi_in;
   logic [ODD_W-1:0]   lo_ff, lo_in;
   logic               ovf_ff, ovf_in;
   logic               bank_ff;
   logic [1:0]         inflight_ff, inflight_in;
   logic               accept;
   logic               has_room;
   logic               odd_lower;

   // Both banks owned by the queue or the back end: hold off new words
   assign busy      = (inflight_ff == 2'd2);
   assign accept    = start && !busy;
   assign has_room  = (cnt_ff < FULL_COUNT);
   assign odd_lower = req_embed_level[0] && ({1'b0, req_embed_level} < lo_ff);

   // Update the line summary for an accepted word
   always_comb begin
      cnt_in = cnt_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (has_room) begin
            cnt_in = cnt_ff + 1'b1;
            if (req_embed_level > hi_ff) begin
               hi_in = req_embed_level;
            end
            if (odd_lower) begin
               lo_in = {1'b0, req_embed_level};
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // Hand the finished line to the queue
   assign push       = accept && req_last_word;
   assign push_bank  = bank_ff;
   assign push_count = cnt_in;
   assign push_info  = '{highest: hi_in, lowest_odd: lo_in, overflow: ovf_in};

   // Track banks in flight
   always_comb begin
      inflight_in = inflight_ff;
      case ({push, release_line})
         2'b10:   inflight_in = inflight_ff + 2'd1;
         2'b01:   inflight_in = inflight_ff - 2'd1;
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         hi_ff       <= '0;
         lo_ff       <= NO_ODD_LEVEL;
         ovf_ff      <= 1'b0;
         bank_ff     <= 1'b0;
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
         if (push) begin
            cnt_ff  <= '0;
            hi_ff   <= '0;
            lo_ff   <= NO_ODD_LEVEL;
            ovf_ff  <= 1'b0;
            bank_ff <= !bank_ff;
         end else begin
            cnt_ff <= cnt_in;
            hi_ff  <= hi_in;
            lo_ff  <= lo_in;
            ovf_ff <= ovf_in;
         end
      end
   end

   // Line store: written by the front end, read by the back end
   always_ff @(posedge clock) begin
      if (accept && has_room) begin
         store_mem[bank_ff][cnt_ff[AW-1:0]] <= '{word_index: req_word_index,
                                                level: req_embed_level};
      end
      rd_data_ff <= store_mem[rd_bank][rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bdr_desc_fifo.sv
// Two-entry queue of line descriptors between the front end and the back end.
// Depends on bdr_pkg.
module bdr_desc_fifo import bdr_pkg::*; #(
   parameter int MAX_WORDS = 64,
   localparam int CW = $clog2(MAX_WORDS + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  logic           push_bank,
   input  logic [CW-1:0]  push_count,
   input  line_info_type  push_info,
   input  logic           pop,
   output logic           empty,
   output logic           head_bank,
   output logic [CW-1:0]  head_count,
   output line_info_type  head_info
);

   logic           bank_mem  [2];
   logic [CW-1:0]  count_mem [2];
   line_info_type  info_mem  [2];
   logic           wr_ptr_ff;
   logic           rd_ptr_ff;
   logic [1:0]     fill_ff, fill_in;

   assign empty      = (fill_ff == 2'd0);
   assign head_bank  = bank_mem[rd_ptr_ff];
   assign head_count = count_mem[rd_ptr_ff];
   assign head_info  = info_mem[rd_ptr_ff];

   // Count entries
   always_comb begin
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // Store the descriptor
   always_ff @(posedge clock) begin
      if (push) begin
         bank_mem[wr_ptr_ff]  <= push_bank;
         count_mem[wr_ptr_ff] <= push_count;
         info_mem[wr_ptr_ff]  <= push_info;
      end
   end

endmodule

### design/bdr_back.sv
// Back end: level passes that reverse runs through a ping-pong work memory, then emission.
// Depends on bdr_pkg; reads the front end's line store.
module bdr_back import bdr_pkg::*; #(
   parameter int MAX_WORDS = 64,
   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
   localparam int CW = $clog2(MAX_WORDS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   output logic                q_pop,
   input  logic                q_bank,
   input  logic [CW-1:0]       q_count,
   input  line_info_type       q_info,
   output logic                store_rd_bank,
   output logic [AW-1:0]       store_rd_addr,
   input  entry_type           store_rd_data,
   output logic                release_line,
   output logic                rsp_strobe,
   output logic [IDX_W-1:0]    rsp_visual_word_index,
   output logic                rsp_last_result,
   output logic                rsp_overflow
);

   back_state_type   state_ff, state_in;
   entry_type        work_mem [2][MAX_WORDS];
   entry_type        work_rd_ff;
   entry_type        src_data;
   entry_type        hold_ff, hold_in;
   line_info_type    info_ff, info_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             bank_ff, bank_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             first_ff, first_in;
   logic             half_ff, half_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    r_ff, r_in;
   logic [CW-1:0]    w_ff, w_in;
   logic             trail_ff, trail_in;
   logic             strobe_ff, strobe_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             last_ff, last_in;
   logic             ovf_ff, ovf_in;

   logic [CW-1:0]    rd_addr;
   logic             wr_en;
   logic [CW-1:0]    wr_addr;
   entry_type        wr_data;

   logic [CW-1:0]    ptr_next;
   logic [CW-1:0]    w_next;
   logic             at_or_above;
   logic             more_after_ptr;
   logic             rev_more;
   logic             copy_more;
   logic             last_level;
   logic             pass_done;
   back_state_type   pass_exit;

   // Select the pass source and derive the step conditions
   always_comb begin
      src_data       = first_ff ? store_rd_data : work_rd_ff;
      ptr_next       = ptr_ff + 1'b1;
      w_next         = w_ff + 1'b1;
      at_or_above    = (src_data.level >= lvl_ff);
      more_after_ptr = (ptr_next < cnt_ff);
      rev_more       = (r_ff > i_ff);
      copy_more      = (w_next < cnt_ff);
      last_level     = (lvl_ff == info_ff.lowest_odd[LVL_W-1:0]);
      pass_exit      = last_level ? BK_EMIT_ISSUE : BK_SCAN_ISSUE;
      case (state_ff)
         BK_SCAN: pass_done = !at_or_above && (ptr_ff == i_ff) && !more_after_ptr;
         BK_REV:  pass_done = !rev_more && !trail_ff;
         BK_COPY: pass_done = !copy_more;
         default: pass_done = 1'b0;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = (q_info.lowest_odd == NO_ODD_LEVEL) ? BK_EMIT_ISSUE : BK_SCAN_ISSUE;
            end
         end
         BK_SCAN_ISSUE: state_in = BK_SCAN;
         BK_SCAN: begin
            if (pass_done) begin
               state_in = pass_exit;
            end else if (at_or_above) begin
               state_in = more_after_ptr ? BK_SCAN : BK_REV;
            end else if (ptr_ff == i_ff) begin
               state_in = BK_SCAN;
            end else begin
               state_in = BK_REV;
            end
         end
         BK_REV: begin
            if (rev_more) begin
               state_in = BK_REV;
            end else if (trail_ff) begin
               state_in = BK_COPY;
            end else begin
               state_in = pass_exit;
            end
         end
         BK_COPY:       state_in = copy_more ? BK_SCAN : pass_exit;
         BK_EMIT_ISSUE: state_in = BK_EMIT;
         BK_EMIT:       state_in = more_after_ptr ? BK_EMIT : BK_IDLE;
         default:       state_in = BK_IDLE;
      endcase
   end

   // Datapath, memory control and result outputs
   always_comb begin
      q_pop        = 1'b0;
      release_line = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = w_ff;
      wr_data      = src_data;
      hold_in      = hold_ff;
      info_in      = info_ff;
      cnt_in       = cnt_ff;
      bank_in      = bank_ff;
      lvl_in       = lvl_ff;
      first_in     = first_ff;
      half_in      = half_ff;
      i_in         = i_ff;
      ptr_in       = ptr_ff;
      r_in         = r_ff;
      w_in         = w_ff;
      trail_in     = trail_ff;
      strobe_in    = 1'b0;
      idx_in       = idx_ff;
      last_in      = 1'b0;
      ovf_in       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            // Take the next line
            if (!q_empty) begin
               q_pop    = 1'b1;
               cnt_in   = q_count;
               info_in  = q_info;
               bank_in  = q_bank;
               lvl_in   = q_info.highest;
               first_in = 1'b1;
               half_in  = 1'b0;
               i_in     = '0;
               ptr_in   = '0;
            end
         end
         BK_SCAN_ISSUE: rd_addr = ptr_ff;
         BK_SCAN: begin
            if (at_or_above) begin
               if (more_after_ptr) begin
                  // Extend the run
                  rd_addr = ptr_next;
                  ptr_in  = ptr_next;
               end else begin
                  // Run reaches the line end: reverse it
                  rd_addr  = ptr_ff;
                  r_in     = ptr_ff;
                  w_in     = i_ff;
                  trail_in = 1'b0;
               end
            end else if (ptr_ff == i_ff) begin
               // Word below the level: copy in place
               wr_en   = 1'b1;
               wr_addr = i_ff;
               wr_data = src_data;
               if (more_after_ptr) begin
                  rd_addr = ptr_next;
                  ptr_in  = ptr_next;
                  i_in    = ptr_next;
               end
            end else begin
               // Run ends before a lower word: hold it and reverse the run
               hold_in  = src_data;
               trail_in = 1'b1;
               rd_addr  = ptr_ff - 1'b1;
               r_in     = ptr_ff - 1'b1;
               w_in     = i_ff;
            end
         end
         BK_REV: begin
            wr_en   = 1'b1;
            wr_addr = w_ff;
            wr_data = src_data;
            if (rev_more) begin
               rd_addr = r_ff - 1'b1;
               r_in    = r_ff - 1'b1;
               w_in    = w_next;
            end else if (trail_ff) begin
               w_in = w_next;
            end
         end
         BK_COPY: begin
            // Place the word that closed the run
            wr_en   = 1'b1;
            wr_addr = w_ff;
            wr_data = hold_ff;
            if (copy_more) begin
               rd_addr = w_next;
               ptr_in  = w_next;
               i_in    = w_next;
            end
         end
         BK_EMIT_ISSUE: rd_addr = ptr_ff;
         BK_EMIT: begin
            strobe_in = 1'b1;
            idx_in    = src_data.word_index;
            last_in   = !more_after_ptr;
            ovf_in    = info_ff.overflow;
            if (more_after_ptr) begin
               rd_addr = ptr_next;
               ptr_in  = ptr_next;
            end else begin
               release_line = 1'b1;
            end
         end
         default: begin
            rd_addr = '0;
         end
      endcase

      // Close a pass: swap work halves, step the level down unless this was the last level
      if (pass_done) begin
         first_in = 1'b0;
         half_in  = !half_ff;
         i_in     = '0;
         ptr_in   = '0;
         if (!last_level) begin
            lvl_in = lvl_ff - 1'b1;
         end
      end
   end

   assign store_rd_bank = bank_ff;
   assign store_rd_addr = rd_addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      info_ff  <= info_in;
      cnt_ff   <= cnt_in;
      bank_ff  <= bank_in;
      lvl_ff   <= lvl_in;
      first_ff <= first_in;
      half_ff  <= half_in;
      i_ff     <= i_in;
      ptr_ff   <= ptr_in;
      r_ff     <= r_in;
      w_ff     <= w_in;
      trail_ff <= trail_in;
      idx_ff   <= idx_in;
      last_ff  <= last_in;
      ovf_ff   <= ovf_in;
   end

   // Work memory: read one half, write the other
   always_ff @(posedge clock) begin
      if (wr_en) begin
         work_mem[!half_ff][wr_addr[AW-1:0]] <= wr_data;
      end
      work_rd_ff <= work_mem[half_ff][rd_addr[AW-1:0]];
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_visual_word_index = idx_ff;
   assign rsp_last_result       = last_ff && strobe_ff;
   assign rsp_overflow          = ovf_ff && strobe_ff;

endmodule

### design/bidi_level_run_reorder_top.sv
// Words load one per cycle while busy is low; after the last word, a level pass runs for each
// level from the highest down to the lowest odd (n stored words: an issue state, one scan step
// per word, one more step per word moved by a reverse or placed after a run); the results
// then stream one per cycle, registered at the outputs after an emit issue state.
// Two line banks let the next line load while one reorders; busy rises only when both banks
// are taken. The receiver cannot stall. Synchronous reset empties the queue and banks.
module bidi_level_run_reorder_top import bdr_pkg::*; #(
   parameter int MAX_WORDS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [IDX_W-1:0] req_word_index,
   input  logic [LVL_W-1:0] req_embed_level,
   input  logic             req_last_word,
   output logic             rsp_strobe,
   output logic [IDX_W-1:0] rsp_visual_word_index,
   output logic             rsp_last_result,
   output logic             rsp_overflow
);

   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CW = $clog2(MAX_WORDS + 1);

   logic           push;
   logic           push_bank;
   logic [CW-1:0]  push_count;
   line_info_type  push_info;
   logic           q_pop;
   logic           q_empty;
   logic           q_bank;
   logic [CW-1:0]  q_count;
   line_info_type  q_info;
   logic           store_rd_bank;
   logic [AW-1:0]  store_rd_addr;
   entry_type      store_rd_data;
   logic           release_line;

   // Load words and summarize each line
   bdr_front #(.MAX_WORDS(MAX_WORDS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_word_index  (req_word_index),
      .req_embed_level (req_embed_level),
      .req_last_word   (req_last_word),
      .busy            (busy),
      .release_line    (release_line),
      .push            (push),
      .push_bank       (push_bank),
      .push_count      (push_count),
      .push_info       (push_info),
      .rd_bank         (store_rd_bank),
      .rd_addr         (store_rd_addr),
      .rd_data         (store_rd_data)
   );

   // Queue finished lines
   bdr_desc_fifo #(.MAX_WORDS(MAX_WORDS)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_bank  (push_bank),
      .push_count (push_count),
      .push_info  (push_info),
      .pop        (q_pop),
      .empty      (q_empty),
      .head_bank  (q_bank),
      .head_count (q_count),
      .head_info  (q_info)
   );

   // Reorder and emit
   bdr_back #(.MAX_WORDS(MAX_WORDS)) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_empty               (q_empty),
      .q_pop                 (q_pop),
      .q_bank                (q_bank),
      .q_count               (q_count),
      .q_info                (q_info),
      .store_rd_bank         (store_rd_bank),
      .store_rd_addr         (store_rd_addr),
      .store_rd_data         (store_rd_data),
      .release_line          (release_line),
      .rsp_strobe            (rsp_strobe),
      .rsp_visual_word_index (rsp_visual_word_index),
      .rsp_last_result       (rsp_last_result),
      .rsp_overflow          (rsp_overflow)
   );

endmodule

### design/bdr_checker.sv
// Port-level checks for the bidi level-run reorder block, bound to the top level.
// Depends on bdr_pkg for field widths.
module bdr_checker import bdr_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [IDX_W-1:0] req_word_index,
   input logic [LVL_W-1:0] req_embed_level,
   input logic             req_last_word,
   input logic             rsp_strobe,
   input logic [IDX_W-1:0] rsp_visual_word_index,
   input logic             rsp_last_result,
   input logic             rsp_overflow
);

   // A line streams out without gaps until its final transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_result |=> rsp_strobe)
      else $error("result stream of a line broke before its last transfer");

   // Overflow flag is the same on every result of one line
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(rsp_strobe) && !$past(rsp_last_result)
      |-> rsp_overflow == $past(rsp_overflow))
      else $error("overflow flag changed within a line");

   // Line markers only appear on a transfer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_last_result || rsp_overflow) |-> rsp_strobe)
      else $error("result marker without a transfer");

   // Leaving reset, both banks are free and no result is out
   assert property (@(posedge clock)
      $fell(reset) |-> !busy && !rsp_strobe)
      else $error("busy or result right after reset");

endmodule

bind bidi_level_run_reorder_top bdr_checker u_bdr_checker (.*);

### sim/tb_bidi_level_run_reorder_top.sv
// Self-checking testbench for bidi_level_run_reorder_top: feeds lines of words and
// checks the visual word order, last marker and overflow flag of every result transfer.
// Depends on bdr_pkg and the top level, which needs the front end, queue and back end.
module tb_bidi_level_run_reorder_top;
   import bdr_pkg::*;

   localparam int MAX_WORDS = 64;

   // One expected visual-order result
   typedef struct {
      logic [IDX_W-1:0] word_index;
      logic             last;
      logic             overflow;
   } visual_word_type;

   // Predicts the visual order of each line and checks the results against it
   class visual_order_board;
      logic [IDX_W-1:0] index_mem [MAX_WORDS];
      logic [LVL_W-1:0] level_mem [MAX_WORDS];
      int               word_count;
      logic [LVL_W-1:0] highest;
      logic [ODD_W-1:0] lowest_odd;
      bit               overflow_seen;
      visual_word_type  visual_queue [$];
      int               mismatches;

      function new();
         mismatches = 0;
         clear_line();
      endfunction

      function void clear_line();
         word_count    = 0;
         highest       = '0;
         lowest_odd    = NO_ODD_LEVEL;
         overflow_seen = 1'b0;
      endfunction

      function int pending();
         return visual_queue.size();
      endfunction

      // Note one accepted word; on the last word, queue the whole reordered line
      function void note_word(logic [IDX_W-1:0] idx, logic [LVL_W-1:0] lvl, bit last);
         int              pos [MAX_WORDS];
         int              lv;
         int              k;
         int              run_end;
         int              a;
         int              b;
         int              t;
         visual_word_type item;
         if (word_count < MAX_WORDS) begin
            index_mem[word_count] = idx;
            level_mem[word_count] = lvl;
            word_count++;
            if (lvl > highest)
               highest = lvl;
            if (lvl[0] && {1'b0, lvl} < lowest_odd)
               lowest_odd = {1'b0, lvl};
         end else begin
            overflow_seen = 1'b1;
         end
         if (!last)
            return;
         for (k = 0; k < word_count; k++)
            pos[k] = k;
         // Reverse maximal runs at or above each level, highest down to lowest odd
         if (lowest_odd != NO_ODD_LEVEL) begin
            for (lv = int'(highest); lv >= int'(lowest_odd); lv--) begin
               k = 0;
               while (k < word_count) begin
                  if (int'(level_mem[pos[k]]) >= lv) begin
                     run_end = k;
                     while (run_end < word_count && int'(level_mem[pos[run_end]]) >= lv)
                        run_end++;
                     a = k;
                     b = run_end - 1;
                     while (a < b) begin
                        t      = pos[a];
                        pos[a] = pos[b];
                        pos[b] = t;
                        a++;
                        b--;
                     end
                     k = run_end;
                  end else begin
                     k++;
                  end
               end
            end
         end
         for (k = 0; k < word_count; k++) begin
            item.word_index = index_mem[pos[k]];
            item.last       = (k == word_count - 1);
            item.overflow   = overflow_seen;
            visual_queue.insert(visual_queue.size(), item);
         end
         clear_line();
      endfunction

      // Compare one result transfer with the oldest expectation
      function void check_word(logic [IDX_W-1:0] vis, logic last, logic ovf);
         visual_word_type exp_item;
         if (visual_queue.size() == 0) begin
            $error("unexpected result: visual_word_index %0d last %0b overflow %0b",
                   vis, last, ovf);
            mismatches++;
            return;
         end
         exp_item = visual_queue.pop_front();
         if (vis !== exp_item.word_index) begin
            $error("visual_word_index: expected %0d, actual %0d", exp_item.word_index, vis);
            mismatches++;
         end
         if (last !== exp_item.last) begin
            $error("last_result: expected %0b, actual %0b", exp_item.last, last);
            mismatches++;
         end
         if (ovf !== exp_item.overflow) begin
            $error("overflow: expected %0b, actual %0b", exp_item.overflow, ovf);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   logic [IDX_W-1:0] req_word_index;
   logic [LVL_W-1:0] req_embed_level;
   logic             req_last_word;
   logic             rsp_strobe;
   logic [IDX_W-1:0] rsp_visual_word_index;
   logic             rsp_last_result;
   logic             rsp_overflow;

   visual_order_board board;
   int                words_sent;

   bidi_level_run_reorder_top #(.MAX_WORDS(MAX_WORDS)) dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_word_index        (req_word_index),
      .req_embed_level       (req_embed_level),
      .req_last_word         (req_last_word),
      .rsp_strobe            (rsp_strobe),
      .rsp_visual_word_index (rsp_visual_word_index),
      .rsp_last_result       (rsp_last_result),
      .rsp_overflow          (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check every result transfer at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         board.check_word(rsp_visual_word_index, rsp_last_result, rsp_overflow);
   end

   // Drive one word, with an optional idle burst first, and hold it until transferred
   task automatic send_word(input logic [IDX_W-1:0] idx, input logic [LVL_W-1:0] lvl,
                            input bit last, input bit idle_on);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start           <= 1'b1;
      req_word_index  <= idx;
      req_embed_level <= lvl;
      req_last_word   <= last;
      do @(posedge clock); while (busy);
      board.note_word(idx, lvl, last);
      words_sent++;
   endtask

   // Send a line of random words whose levels form runs
   task automatic send_random_line(input int n, input int lvl_max, input bit idle_on);
      int lvl;
      int k;
      lvl = $urandom_range(0, lvl_max);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 1) == 0)
            lvl = $urandom_range(0, lvl_max);
         send_word(IDX_W'($urandom_range(0, 65535)), LVL_W'(lvl), k == n - 1, idle_on);
      end
   endtask

   initial begin
      int mixed_levels [7];
      int even_levels [3];
      int top_levels [5];
      int random_start;
      int n;
      int lvl_max;
      int k;

      mixed_levels    = '{0, 1, 1, 2, 2, 1, 0};
      even_levels     = '{2, 4, 2};
      top_levels      = '{127, 126, 125, 0, 124};
      board           = new();
      words_sent      = 0;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_word_index  <= '0;
      req_embed_level <= '0;
      req_last_word   <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: single words, extremes of the index, mixed, even-only and top levels
      send_word(16'h0000, 7'd0, 1'b1, 1'b0);
      send_word(16'hFFFF, 7'd1, 1'b1, 1'b0);
      send_word(16'hFFFF, 7'd0, 1'b0, 1'b0);
      send_word(16'h0000, 7'd0, 1'b1, 1'b0);
      for (k = 0; k < 7; k++)
         send_word(IDX_W'($urandom_range(0, 65535)), LVL_W'(mixed_levels[k]), k == 6, 1'b1);
      for (k = 0; k < 3; k++)
         send_word(IDX_W'($urandom_range(0, 65535)), LVL_W'(even_levels[k]), k == 2, 1'b1);
      for (k = 0; k < 5; k++)
         send_word(IDX_W'($urandom_range(0, 65535)), LVL_W'(top_levels[k]), k == 4, 1'b1);

      // Random: first overflow the store, then mostly short lines, some longer ones
      random_start = words_sent;
      send_random_line(65 + $urandom_range(0, 5), 7, 1'b1);
      while (words_sent - random_start < 100) begin
         if ($urandom_range(0, 9) == 0) begin
            n       = $urandom_range(9, 16);
            lvl_max = 7;
         end else begin
            n       = $urandom_range(1, 8);
            lvl_max = ($urandom_range(0, 4) == 0) ? 127 : 7;
         end
         send_random_line(n, lvl_max,
                          (words_sent - random_start < 80) && $urandom_range(0, 2) != 0);
      end
      start <= 1'b0;

      // Drain the expected results, then watch for strays
      while (board.pending() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // End a hung run
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
